>>> sv/dltt_pkg.sv
package dltt_pkg;

  localparam int DLTT_ENTRIES = 32;

  localparam int HANDLER_W = 16;
  localparam int ARG_W     = 32;
  localparam int DELAY_W   = 31;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 5;
  localparam int COUNT_W   = 5;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_NO_MATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [HANDLER_W-1:0] handler;
    logic [ARG_W-1:0]     arg;
    logic [DELAY_W-1:0]   delta;
  } entry_t;

endpackage

>>> sv/dltt_req_if.sv
interface dltt_req_if;
  import dltt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [HANDLER_W-1:0] handler_id;
  logic [ARG_W-1:0]     arg_tag;
  logic [DELAY_W-1:0]   delay_ticks;

  modport source (
    output valid, action, handler_id, arg_tag, delay_ticks,
    input  ready
  );

  modport sink (
    input  valid, action, handler_id, arg_tag, delay_ticks,
    output ready
  );
endinterface

>>> sv/dltt_rsp_if.sv
interface dltt_rsp_if;
  import dltt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  live_count;

  modport source (
    output valid, status, slot, live_count,
    input  ready
  );

  modport sink (
    input  valid, status, slot, live_count,
    output ready
  );
endinterface

>>> sv/delta_list_timeout_table_top.sv
// Timeout table kept as a delta list in one synchronous RAM (ENTRIES slots, one holds
// back as the full margin, so at most ENTRIES-1 are live). Each request word is an insert
// or a remove and yields exactly one response word. The table does at most one RAM read and
// one RAM write per cycle: first a scan up to the insert point or the match, then a shift of
// the entries behind it. An insert into a full table skips the scan and the shift. One
// request is in flight at a time; a new request is taken while the previous response still
// waits in the output register. The RAM needs no clearing after reset: only slots below the
// live count are used.
module delta_list_timeout_table_top #(
  parameter int ENTRIES = dltt_pkg::DLTT_ENTRIES
) (
  input logic        clk,
  input logic        rst,
  dltt_req_if.sink   req,
  dltt_rsp_if.source rsp
);
  import dltt_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t state, state_next;

  logic                 act;
  logic [HANDLER_W-1:0] hid;
  logic [ARG_W-1:0]     tag;
  logic [DELAY_W-1:0]   t_rem, t_rem_next;
  logic [DELAY_W-1:0]   delta_keep, delta_keep_next;
  logic [IW-1:0]        idx, idx_next;
  logic [IW-1:0]        src, src_next;
  logic [IW-1:0]        live, live_next;
  status_t              res_status, res_status_next;
  logic [IW-1:0]        res_slot, res_slot_next;
  logic                 out_load;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  entry_t               ram_wdata, rd;

  logic                 req_fire;
  logic                 in_range;
  logic                 match;
  logic [IW:0]          idx_inc, src_inc;
  logic [IW+SLOT_W-1:0]  slot_pad;
  logic [IW+COUNT_W-1:0] live_pad;

  dltt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign in_range  = (idx < live);
  assign match     = (rd.handler == hid) && (rd.arg == tag);
  assign idx_inc   = {1'b0, idx} + 1'b1;
  assign src_inc   = {1'b0, src} + 1'b1;

  always_comb begin
    state_next      = state;
    t_rem_next      = t_rem;
    delta_keep_next = delta_keep;
    idx_next        = idx;
    src_next        = src;
    live_next       = live;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    out_load        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = rd;
    ram_raddr       = idx_inc[IW-1:0];

    unique case (state)
      S_IDLE: begin
        ram_raddr = '0;
        if (req_fire) begin
          idx_next   = '0;
          t_rem_next = req.delay_ticks;
          if (req.action == ACT_INSERT && live == LAST) begin
            res_status_next = ST_FULL;
            res_slot_next   = '0;
            state_next      = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (act == ACT_INSERT) begin
          if (in_range && rd.delta <= t_rem) begin
            // consume this delta and keep walking
            t_rem_next = t_rem - rd.delta;
            idx_next   = idx_inc[IW-1:0];
          end else begin
            res_status_next = ST_INSERTED;
            res_slot_next   = idx;
            src_next        = live - 1'b1;
            ram_raddr       = live - 1'b1;
            state_next      = in_range ? S_SHIFT_UP : S_PLACE;
          end
        end else begin
          if (!in_range) begin
            res_status_next = ST_NO_MATCH;
            res_slot_next   = '0;
            state_next      = S_DONE;
          end else if (match) begin
            res_status_next = ST_REMOVED;
            res_slot_next   = idx;
            delta_keep_next = rd.delta;
            src_next        = idx_inc[IW-1:0];
            state_next      = (idx_inc < {1'b0, live}) ? S_SHIFT_DN : S_DONE;
          end else begin
            idx_next = idx_inc[IW-1:0];
          end
        end
      end

      S_SHIFT_UP: begin
        // move src up one slot; the old occupant of the insert point gives up t_rem
        ram_we    = 1'b1;
        ram_waddr = src_inc[IW-1:0];
        if (src == idx) begin
          ram_wdata.delta = rd.delta - t_rem;
          state_next      = S_PLACE;
        end
        ram_raddr = src - 1'b1;
        src_next  = src - 1'b1;
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = '{handler: hid, arg: tag, delta: t_rem};
        state_next = S_DONE;
      end

      S_SHIFT_DN: begin
        // close the gap; the follower absorbs the removed delta
        ram_we    = 1'b1;
        ram_waddr = src - 1'b1;
        if (src == idx_inc[IW-1:0]) begin
          ram_wdata.delta = rd.delta + delta_keep;
        end
        ram_raddr = src_inc[IW-1:0];
        src_next  = src_inc[IW-1:0];
        if (src_inc == {1'b0, live}) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          out_load = 1'b1;
          if (res_status == ST_INSERTED) begin
            live_next = live + 1'b1;
          end else if (res_status == ST_REMOVED) begin
            live_next = live - 1'b1;
          end
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign slot_pad = {{SLOT_W{1'b0}}, res_slot};
  assign live_pad = {{COUNT_W{1'b0}}, live_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      live  <= '0;
    end else begin
      state <= state_next;
      live  <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      act <= req.action;
      hid <= req.handler_id;
      tag <= req.arg_tag;
    end
    t_rem      <= t_rem_next;
    delta_keep <= delta_keep_next;
    idx        <= idx_next;
    src        <= src_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status     <= res_status;
      rsp.slot       <= slot_pad[SLOT_W-1:0];
      rsp.live_count <= live_pad[COUNT_W-1:0];
    end
  end
endmodule

>>> sv/dltt_ram.sv
module dltt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/dltt_checker.sv
module dltt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [dltt_pkg::STATUS_W-1:0] rsp_status,
  input logic [dltt_pkg::SLOT_W-1:0]   rsp_slot,
  input logic [dltt_pkg::COUNT_W-1:0]  rsp_live_count
);
  import dltt_pkg::*;

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
      && $stable(rsp_live_count))
    else $error("response word changed while stalled");

  // a full table or a missed remove reports slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NO_MATCH) |-> rsp_slot == '0)
    else $error("nonzero slot on failed operation");

  // one request in flight: never two accepts on consecutive edges
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while one is in flight");

  // a response never appears the edge right after an accept
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_valid && req_ready))
    else $error("response too early after accept");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind delta_list_timeout_table_top dltt_checker u_dltt_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .rsp_slot       (rsp.slot),
  .rsp_live_count (rsp.live_count)
);

>>> tb/tb_delta_list_timeout_table_top.sv
module tb_delta_list_timeout_table_top;
  import dltt_pkg::*;

  localparam int ENTRIES     = DLTT_ENTRIES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYC  = ENTRIES + 12;
  localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

  typedef struct {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  live_count;
  } timeout_rsp_t;

  logic clk;
  logic rst;

  dltt_req_if req_if ();
  dltt_rsp_if rsp_if ();

  delta_list_timeout_table_top #(.ENTRIES(ENTRIES)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // shadow of the timeout table
  logic [HANDLER_W-1:0] tbl_handler [ENTRIES];
  logic [ARG_W-1:0]     tbl_arg     [ENTRIES];
  logic [DELAY_W-1:0]   tbl_delta   [ENTRIES];
  int                   live_n;

  timeout_rsp_t expected_rsp_q [$];
  int           mismatch_cnt;
  int           cycle_cnt;

  // sender burst shaping and receiver stall pattern
  int burst_left;
  int max_burst;
  int max_gap;
  int stall_pct;
  int max_stall;
  int stall_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic timeout_rsp_t apply_timeout_op(action_t act, logic [HANDLER_W-1:0] hid,
                                                    logic [ARG_W-1:0] tag,
                                                    logic [DELAY_W-1:0] dly);
    timeout_rsp_t       r;
    int                 n;
    int                 i;
    int                 k;
    logic [DELAY_W-1:0] rem;
    n   = (live_n > ENTRIES - 1) ? ENTRIES - 1 : live_n;
    rem = dly;
    i   = 0;
    r.slot = '0;
    if (act == ACT_INSERT) begin
      // walk past every entry that expires no later than the new one
      while (i < n && tbl_delta[i] <= rem) begin
        rem = rem - tbl_delta[i];
        i++;
      end
      if (n >= ENTRIES - 1) begin
        r.status = ST_FULL;
      end else begin
        if (i < n) tbl_delta[i] = tbl_delta[i] - rem;
        for (k = n; k > i; k--) begin
          tbl_handler[k] = tbl_handler[k-1];
          tbl_arg[k]     = tbl_arg[k-1];
          tbl_delta[k]   = tbl_delta[k-1];
        end
        tbl_handler[i] = hid;
        tbl_arg[i]     = tag;
        tbl_delta[i]   = rem;
        live_n   = n + 1;
        r.status = ST_INSERTED;
        r.slot   = i[SLOT_W-1:0];
      end
    end else begin
      while (i < n && !(tbl_handler[i] == hid && tbl_arg[i] == tag)) i++;
      if (i >= n) begin
        r.status = ST_NO_MATCH;
      end else begin
        if (i + 1 < n) tbl_delta[i+1] = tbl_delta[i+1] + tbl_delta[i];
        for (k = i; k + 1 < n; k++) begin
          tbl_handler[k] = tbl_handler[k+1];
          tbl_arg[k]     = tbl_arg[k+1];
          tbl_delta[k]   = tbl_delta[k+1];
        end
        live_n   = n - 1;
        r.status = ST_REMOVED;
        r.slot   = i[SLOT_W-1:0];
      end
    end
    r.live_count = live_n[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_op(action_t act, logic [HANDLER_W-1:0] hid, logic [ARG_W-1:0] tag,
                         logic [DELAY_W-1:0] dly);
    int gap;
    @(negedge clk);
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.handler_id  <= hid;
    req_if.arg_tag     <= tag;
    req_if.delay_ticks <= dly;
    do @(posedge clk); while (!req_if.ready);
    expected_rsp_q.push_back(apply_timeout_op(act, hid, tag, dly));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, max_burst);
      if (max_gap > 0) begin
        gap = $urandom_range(1, max_gap);
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_random_op(int insert_pct);
    logic [HANDLER_W-1:0] hid;
    logic [ARG_W-1:0]     tag;
    logic [DELAY_W-1:0]   dly;
    int                   sel;
    int                   idx;
    hid = ($urandom_range(1) == 0) ? HANDLER_W'($urandom_range(7)) : HANDLER_W'($urandom);
    tag = ($urandom_range(1) == 0) ? ARG_W'($urandom_range(3)) : ARG_W'($urandom);
    sel = $urandom_range(99);
    if (sel < 40) dly = DELAY_W'($urandom_range(15));
    else if (sel < 70) dly = DELAY_W'($urandom_range(1000));
    else dly = DELAY_W'($urandom);
    if ($urandom_range(99) < insert_pct) begin
      send_op(ACT_INSERT, hid, tag, dly);
    end else begin
      sel = $urandom_range(99);
      // mostly aim at a live entry, sometimes at its handle with a wrong tag
      if (live_n > 0 && sel < 80) begin
        idx = $urandom_range(live_n - 1);
        hid = tbl_handler[idx];
        tag = tbl_arg[idx];
        if (sel >= 70) tag[$urandom_range(ARG_W - 1)] ^= 1'b1;
      end
      send_op(ACT_REMOVE, hid, tag, dly);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic test_directed();
    max_burst = 3;
    max_gap   = 4;
    stall_pct = 20;
    max_stall = 5;
    send_op(ACT_REMOVE, '0, '0, '0);
    send_op(ACT_INSERT, '0, '0, '0);
    send_op(ACT_INSERT, '1, '1, DELAY_MAX);
    // equal expiry goes behind the existing entry
    send_op(ACT_INSERT, 16'h5555, 32'haaaa_aaaa, '0);
    send_op(ACT_INSERT, 16'haaaa, 32'h5555_5555, 31'd100);
    send_op(ACT_INSERT, 16'h0001, 32'h0000_0001, 31'd100);
    send_op(ACT_INSERT, 16'h0001, 32'h0000_0001, 31'h2aaa_aaaa);
    send_op(ACT_INSERT, 16'h8000, 32'h8000_0000, 31'h5555_5555);
    send_op(ACT_REMOVE, '1, '0, DELAY_MAX);
    send_op(ACT_REMOVE, '0, '1, '0);
    send_op(ACT_REMOVE, 16'h0001, 32'h0000_0001, '0);
    send_op(ACT_REMOVE, 16'haaaa, 32'h5555_5555, '0);
    send_op(ACT_REMOVE, '0, '0, '0);
    send_op(ACT_REMOVE, '1, '1, '0);
    send_op(ACT_REMOVE, 16'h5555, 32'haaaa_aaaa, '0);
    send_op(ACT_REMOVE, 16'h0001, 32'h0000_0001, '0);
    send_op(ACT_REMOVE, 16'h8000, 32'h8000_0000, '0);
    send_op(ACT_REMOVE, 16'h8000, 32'h8000_0000, '0);
    wait_idle();
  endtask

  task automatic test_table_full();
    max_burst = 8;
    max_gap   = 2;
    stall_pct = 10;
    max_stall = 3;
    while (live_n < ENTRIES - 1) send_random_op(100);
    repeat (3) send_random_op(100);
    send_random_op(0);
    send_random_op(100);
    send_random_op(100);
    wait_idle();
  endtask

  task automatic test_random_mix();
    int insert_pct [6] = '{70, 50, 30, 60, 85, 45};
    int p;
    for (p = 0; p < 6; p++) begin
      max_burst = (p % 2 == 0) ? 4 : 20;
      max_gap   = (p == 3) ? 0 : 1 + 3 * (p % 3);
      stall_pct = (p == 4) ? 0 : 10 + 10 * (p % 3);
      max_stall = 2 + 6 * (p % 2);
      burst_left = 1;
      repeat (142) send_random_op(insert_pct[p]);
    end
    wait_idle();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      rsp_if.ready <= 1'b0;
      stall_left = $urandom_range(1, max_stall) - 1;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    timeout_rsp_t exp_rsp;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected word status=%0d slot=%0d live_count=%0d", $time,
                 rsp_if.status, rsp_if.slot, rsp_if.live_count);
        mismatch_cnt++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (rsp_if.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                   rsp_if.status);
          mismatch_cnt++;
        end
        if (rsp_if.slot !== exp_rsp.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, exp_rsp.slot, rsp_if.slot);
          mismatch_cnt++;
        end
        if (rsp_if.live_count !== exp_rsp.live_count) begin
          $display("%0t: live_count expected %0d actual %0d", $time, exp_rsp.live_count,
                   rsp_if.live_count);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.action      = ACT_INSERT;
    req_if.handler_id  = '0;
    req_if.arg_tag     = '0;
    req_if.delay_ticks = '0;
    rsp_if.ready       = 1'b0;
    live_n             = 0;
    mismatch_cnt       = 0;
    cycle_cnt          = 0;
    burst_left         = 1;
    max_burst          = 1;
    max_gap            = 0;
    stall_pct          = 0;
    max_stall          = 1;
    stall_left         = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_table_full();
    test_random_mix();
    if (mismatch_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
